>>> src/huffman_trie_decoder_macros.svh
// ----------------------------------------------------------------------------
// huffman trie decoder assertion macros
// shared concurrent assertion forms for the decoder modules
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TRIE_DECODER_MACROS_SVH
`define HUFFMAN_TRIE_DECODER_MACROS_SVH

// same-cycle implication
`define HTD_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hft assertion failed");

// next-cycle implication
`define HTD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hft assertion failed");

`endif

>>> src/hft_pkg.sv
// ----------------------------------------------------------------------------
// hft_pkg
// sizes, codes and shared types of the huffman trie decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hft_pkg;

  localparam int NODE_COUNT    = 512;
  localparam int MAX_CODE_BITS = 32;
  localparam int TOP_BIT       = 7;

  localparam int NODE_W    = $clog2(NODE_COUNT);
  localparam int USED_W    = $clog2(NODE_COUNT + 1);
  localparam int SYM_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int BYTE_BITS = TOP_BIT + 1;
  localparam int SHIFT_W   = MAX_CODE_BITS;
  localparam int CNT_W     = $clog2(MAX_CODE_BITS + 1);
  localparam int LENX_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int ENTRY_W   = 2 * NODE_W + SYM_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SYMBOL = 2'd0,
    ST_ERROR  = 2'd1,
    ST_LOADED = 2'd2,
    ST_FULL   = 2'd3
  } hft_status_t;

  typedef struct packed {
    logic [NODE_W-1:0] zero_child;
    logic [NODE_W-1:0] one_child;
    logic [SYM_W-1:0]  sym;
  } hft_node_t;

  typedef struct packed {
    logic              emit;
    logic              flush;
    logic [SYM_W-1:0]  sym;
    hft_status_t       status;
  } hft_emit_t;

endpackage

`default_nettype wire

>>> src/hft_node_ram.sv
// ----------------------------------------------------------------------------
// hft_node_ram
// simple dual port node table, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hft_node_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 512,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/hft_out_stage.sv
// ----------------------------------------------------------------------------
// hft_out_stage
// holds one pending result until its last flag is known, then the output reg
// ----------------------------------------------------------------------------
`default_nettype none
`include "huffman_trie_decoder_macros.svh"

module hft_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  hft_pkg::hft_emit_t            emit,
  output logic                          emit_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hft_pkg::SYM_W-1:0]     out_symbol,
  output logic [hft_pkg::STATUS_W-1:0]  status,
  output logic                          last
);

  import hft_pkg::*;

  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  hft_status_t      pend_status;
  logic             can_push;
  logic             push;
  logic             push_last;

  always_comb begin
    can_push   = !out_valid || !out_stall;
    emit_ready = !pend_valid || can_push;
    push       = pend_valid && emit_ready && (emit.emit || emit.flush);
    push_last  = !emit.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit.emit && emit_ready) begin
        pend_valid <= 1'b1;
      end else if (emit.flush && emit_ready) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.emit && emit_ready) begin
      pend_sym    <= emit.sym;
      pend_status <= emit.status;
    end
    if (push) begin
      out_symbol <= pend_sym;
      status     <= pend_status;
      last       <= push_last;
    end
  end

  `HTD_ASSERT_NEXT(a_push_not_last, clk, rst, emit.emit && emit_ready && pend_valid, out_valid && !last)
  `HTD_ASSERT_NEXT(a_flush_last, clk, rst, emit.flush && emit_ready && pend_valid, out_valid && last)
  `HTD_ASSERT_IMPLIES(a_nonsym_last, clk, rst, out_valid && status != ST_SYMBOL, last)
  `HTD_ASSERT_IMPLIES(a_nonsym_zero, clk, rst, out_valid && status != ST_SYMBOL, out_symbol == '0)

endmodule

`default_nettype wire

>>> src/hft_walker.sv
// ----------------------------------------------------------------------------
// hft_walker
// bit serial tree walk for code loads and byte decodes over the node table
// ----------------------------------------------------------------------------
`default_nettype none
`include "huffman_trie_decoder_macros.svh"

module hft_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [hft_pkg::BYTE_W-1:0]  data_byte,
  input  logic [hft_pkg::SYM_W-1:0]   symbol,
  input  logic [hft_pkg::CODE_W-1:0]  code_bits,
  input  logic [hft_pkg::LEN_W-1:0]   code_length,
  output hft_pkg::hft_emit_t          emit,
  input  logic                        emit_ready
);

  import hft_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LEV   = 8'b0000_0010,
    S_LINIT = 8'b0000_0100,
    S_LRD   = 8'b0000_1000,
    S_DEV   = 8'b0001_0000,
    S_DCHK  = 8'b0010_0000,
    S_DERR  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [SHIFT_W-1:0]  shreg, shreg_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [NODE_W-1:0]   load_node, load_node_next;
  logic [NODE_W-1:0]   next_node, next_node_next;
  logic [NODE_W-1:0]   current_node, current_node_next;
  logic [USED_W-1:0]   nodes_used, nodes_used_next;
  logic                error_latched, error_latched_next;
  logic [SYM_W-1:0]    load_sym, load_sym_next;
  logic                root_init;
  logic [NODE_W-1:0]   rd_addr_q;

  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr;
  hft_node_t           ram_wdata;
  logic                ram_re;
  logic [NODE_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  hft_node_t           entry;
  hft_node_t           wr_entry;
  logic                bit_msb;
  logic [NODE_W-1:0]   child;
  logic [NODE_W-1:0]   new_node;
  logic                table_full;
  logic [SHIFT_W-1:0]  code_ext;
  logic [SHIFT_W-1:0]  code_aligned;
  logic [SHIFT_W-1:0]  byte_aligned;
  logic [LENX_W-1:0]   len_x;
  logic [CNT_W-1:0]    len_clip;
  logic [CNT_W-1:0]    shamt;

  hft_node_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // root reads as empty until first written
  always_comb begin
    if (rd_addr_q == '0 && !root_init) begin
      entry = '0;
    end else begin
      entry = hft_node_t'(ram_rdata);
    end
    bit_msb    = shreg[SHIFT_W-1];
    child      = bit_msb ? entry.one_child : entry.zero_child;
    new_node   = nodes_used[NODE_W-1:0];
    table_full = (nodes_used >= USED_W'(NODE_COUNT));
    code_ext   = SHIFT_W'(code_bits);
    len_x      = LENX_W'(code_length);
    if (len_x > LENX_W'(MAX_CODE_BITS)) begin
      len_clip = CNT_W'(MAX_CODE_BITS);
    end else begin
      len_clip = CNT_W'(len_x);
    end
    shamt        = CNT_W'(SHIFT_W) - len_clip;
    code_aligned = code_ext << shamt;
    byte_aligned = SHIFT_W'(data_byte) << (SHIFT_W - BYTE_W);
  end

  always_comb begin
    state_next         = state;
    shreg_next         = shreg;
    count_next         = count;
    load_node_next     = load_node;
    next_node_next     = next_node;
    current_node_next  = current_node;
    nodes_used_next    = nodes_used;
    error_latched_next = error_latched;
    load_sym_next      = load_sym;
    wr_entry           = entry;
    ram_we             = 1'b0;
    ram_waddr          = load_node;
    ram_wdata          = entry;
    ram_re             = 1'b0;
    ram_raddr          = current_node;
    emit               = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_LOAD) begin
            shreg_next     = code_aligned;
            count_next     = len_clip;
            load_node_next = '0;
            load_sym_next  = symbol;
            ram_re         = 1'b1;
            ram_raddr      = '0;
            state_next     = S_LEV;
          end else if (error_latched) begin
            state_next = S_DERR;
          end else begin
            shreg_next = byte_aligned;
            count_next = CNT_W'(BYTE_BITS);
            ram_re     = 1'b1;
            ram_raddr  = current_node;
            state_next = S_DEV;
          end
        end
      end
      S_LEV: begin
        if (count == '0) begin
          emit.emit   = 1'b1;
          emit.status = ST_LOADED;
          if (emit_ready) begin
            wr_entry.sym = load_sym;
            ram_we       = 1'b1;
            ram_waddr    = load_node;
            ram_wdata    = wr_entry;
            state_next   = S_FIN;
          end
        end else if (child != '0) begin
          load_node_next = child;
          shreg_next     = shreg << 1;
          count_next     = count - CNT_W'(1);
          ram_re         = 1'b1;
          ram_raddr      = child;
        end else if (table_full) begin
          emit.emit   = 1'b1;
          emit.status = ST_FULL;
          if (emit_ready) begin
            state_next = S_FIN;
          end
        end else begin
          if (bit_msb) begin
            wr_entry.one_child = new_node;
          end else begin
            wr_entry.zero_child = new_node;
          end
          ram_we     = 1'b1;
          ram_waddr  = load_node;
          ram_wdata  = wr_entry;
          state_next = S_LINIT;
        end
      end
      S_LINIT: begin
        ram_we          = 1'b1;
        ram_waddr       = new_node;
        ram_wdata       = '0;
        load_node_next  = new_node;
        nodes_used_next = nodes_used + USED_W'(1);
        shreg_next      = shreg << 1;
        count_next      = count - CNT_W'(1);
        state_next      = S_LRD;
      end
      S_LRD: begin
        ram_re     = 1'b1;
        ram_raddr  = load_node;
        state_next = S_LEV;
      end
      S_DEV: begin
        if (child == '0) begin
          emit.emit   = 1'b1;
          emit.status = ST_ERROR;
          if (emit_ready) begin
            error_latched_next = 1'b1;
            current_node_next  = '0;
            state_next         = S_FIN;
          end
        end else begin
          next_node_next = child;
          ram_re         = 1'b1;
          ram_raddr      = child;
          shreg_next     = shreg << 1;
          count_next     = count - CNT_W'(1);
          state_next     = S_DCHK;
        end
      end
      S_DCHK: begin
        if (entry.sym != '0) begin
          emit.emit   = 1'b1;
          emit.sym    = entry.sym;
          emit.status = ST_SYMBOL;
          if (emit_ready) begin
            current_node_next = '0;
            ram_re            = 1'b1;
            ram_raddr         = '0;
            state_next        = (count == '0) ? S_FIN : S_DEV;
          end
        end else begin
          current_node_next = next_node;
          ram_re            = 1'b1;
          ram_raddr         = next_node;
          state_next        = (count == '0) ? S_FIN : S_DEV;
        end
      end
      S_DERR: begin
        emit.emit   = 1'b1;
        emit.status = ST_ERROR;
        if (emit_ready) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        emit.flush = 1'b1;
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      current_node  <= '0;
      nodes_used    <= USED_W'(1);
      error_latched <= 1'b0;
      root_init     <= 1'b0;
      rd_addr_q     <= '0;
    end else begin
      state         <= state_next;
      current_node  <= current_node_next;
      nodes_used    <= nodes_used_next;
      error_latched <= error_latched_next;
      if (ram_we && ram_waddr == '0) begin
        root_init <= 1'b1;
      end
      if (ram_re) begin
        rd_addr_q <= ram_raddr;
      end
    end
  end

  always_ff @(posedge clk) begin
    shreg     <= shreg_next;
    count     <= count_next;
    load_node <= load_node_next;
    next_node <= next_node_next;
    load_sym  <= load_sym_next;
  end

  `HTD_ASSERT_NEXT(a_err_sticky, clk, rst, error_latched, error_latched)
  `HTD_ASSERT_IMPLIES(a_no_walk_on_err, clk, rst, state == S_DEV, !error_latched)
  `HTD_ASSERT_IMPLIES(a_alloc_free, clk, rst, state == S_LINIT, !table_full)
  `HTD_ASSERT_NEXT(a_root_init, clk, rst, ram_we && ram_waddr == '0, root_init)

endmodule

`default_nettype wire

>>> src/huffman_trie_decoder.sv
// ----------------------------------------------------------------------------
// huffman_trie_decoder
// binary huffman decode tree in a node table, loaded one code at a time
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    op, data_byte, symbol, code_bits, code_length
//  out      out_valid / out_stall  out_symbol, status, last
//
//  decode: each bit of the byte walks one tree level through the DEV and DCHK states
//  load: one tree level per code bit, plus the LINIT and LRD states per newly allocated node
//  reset clears the table at once through the fill count and a root flag
//  one item at a time; in_stall is high from transfer until its results are queued
//  a stalled output holds the walk only when a result must be handed over
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_trie_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [hft_pkg::BYTE_W-1:0]    data_byte,
  input  logic [hft_pkg::SYM_W-1:0]     symbol,
  input  logic [hft_pkg::CODE_W-1:0]    code_bits,
  input  logic [hft_pkg::LEN_W-1:0]     code_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hft_pkg::SYM_W-1:0]     out_symbol,
  output logic [hft_pkg::STATUS_W-1:0]  status,
  output logic                          last
);

  import hft_pkg::*;

  hft_emit_t emit_cmd;
  logic      emit_ready;

  hft_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .data_byte   (data_byte),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .emit        (emit_cmd),
    .emit_ready  (emit_ready)
  );

  hft_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .emit       (emit_cmd),
    .emit_ready (emit_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .status     (status),
    .last       (last)
  );

endmodule

`default_nettype wire
